// ===== rtl/qte_pkg.sv =====
// Shared constants, types and tables for the quaternion to Euler angle pipeline.
package qte_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;
    localparam int SQ_STEPS     = 29;
    localparam int SQ_TOP       = 56;
    localparam int SW           = 35;
    localparam int CW           = 38;
    localparam int ZW           = 28;
    localparam int SQW          = 58;

    localparam logic signed [SW-1:0] ONE_Q28     = SW'(64'sd268435456);
    localparam logic signed [ZW-1:0] HALF_PI_Q24 = ZW'(64'sd26353589);
    localparam logic signed [ZW-1:0] PI_Q13      = ZW'(64'sd25736);
    localparam logic signed [ZW-1:0] HALF_PI_Q13 = ZW'(64'sd12868);
    localparam logic signed [ZW-1:0] ROUND_Q11   = ZW'(64'sd1024);

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } cvec_t;

    typedef struct packed {
        logic [SQW-1:0] rem;
        logic [SQW-1:0] res;
    } sqst_t;

    // atan(2^-i) with 24 fraction bits.
    function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] i);
        logic signed [ZW-1:0] r;
        begin
            case (i)
                5'd0:  r = ZW'(64'sd13176795);
                5'd1:  r = ZW'(64'sd7778716);
                5'd2:  r = ZW'(64'sd4110060);
                5'd3:  r = ZW'(64'sd2086331);
                5'd4:  r = ZW'(64'sd1047214);
                5'd5:  r = ZW'(64'sd524117);
                5'd6:  r = ZW'(64'sd262123);
                5'd7:  r = ZW'(64'sd131069);
                5'd8:  r = ZW'(64'sd65536);
                5'd9:  r = ZW'(64'sd32768);
                5'd10: r = ZW'(64'sd16384);
                5'd11: r = ZW'(64'sd8192);
                5'd12: r = ZW'(64'sd4096);
                5'd13: r = ZW'(64'sd2048);
                5'd14: r = ZW'(64'sd1024);
                5'd15: r = ZW'(64'sd512);
                5'd16: r = ZW'(64'sd256);
                5'd17: r = ZW'(64'sd128);
                5'd18: r = ZW'(64'sd64);
                5'd19: r = ZW'(64'sd32);
                5'd20: r = ZW'(64'sd16);
                5'd21: r = ZW'(64'sd8);
                5'd22: r = ZW'(64'sd4);
                5'd23: r = ZW'(64'sd2);
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    // Moves a vector with negative x into the right half plane.
    function automatic cvec_t pre_rotate(input logic signed [CW-1:0] ys,
                                         input logic signed [CW-1:0] xc);
        cvec_t v;
        begin
            v.x = xc;
            v.y = ys;
            v.z = '0;
            if (xc[CW-1]) begin
                if (!ys[CW-1]) begin
                    v.x = ys;
                    v.y = -xc;
                    v.z = HALF_PI_Q24;
                end else begin
                    v.x = -ys;
                    v.y = xc;
                    v.z = -HALF_PI_Q24;
                end
            end
            return v;
        end
    endfunction

endpackage

// ===== rtl/qte_isqrt_step.sv =====
// One registered digit step of the integer square root.
module qte_isqrt_step import qte_pkg::*; (
    input  logic       aclk,
    input  logic       ce,
    input  logic [4:0] step,
    input  sqst_t      st_in,
    output sqst_t      st_out
);

    sqst_t          st_reg;
    sqst_t          st_next;
    logic [5:0]     sh;
    logic [SQW-1:0] bitv;
    logic [SQW-1:0] trial;

    assign sh    = 6'(SQ_TOP) - {step, 1'b0};
    assign bitv  = SQW'(1) << sh;
    assign trial = st_in.res + bitv;

    always_comb begin
        if (st_in.rem >= trial) begin
            st_next.rem = st_in.rem - trial;
            st_next.res = (st_in.res >> 1) + bitv;
        end else begin
            st_next.rem = st_in.rem;
            st_next.res = st_in.res >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            st_reg <= st_next;
        end
    end

    assign st_out = st_reg;

endmodule

// ===== rtl/qte_cordic_step.sv =====
// One registered vectoring CORDIC iteration.
module qte_cordic_step import qte_pkg::*; (
    input  logic       aclk,
    input  logic       ce,
    input  logic [4:0] step,
    input  cvec_t      v_in,
    output cvec_t      v_out
);

    cvec_t                v_reg;
    cvec_t                v_next;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [ZW-1:0] ang;

    assign dx  = v_in.y >>> step;
    assign dy  = v_in.x >>> step;
    assign ang = atan_lut(step);

    always_comb begin
        if (!v_in.y[CW-1]) begin
            v_next.x = v_in.x + dx;
            v_next.y = v_in.y - dy;
            v_next.z = v_in.z + ang;
        end else begin
            v_next.x = v_in.x - dx;
            v_next.y = v_in.y + dy;
            v_next.z = v_in.z - ang;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            v_reg <= v_next;
        end
    end

    assign v_out = v_reg;

endmodule

// ===== rtl/quaternion_to_euler_zyx_top.sv =====
// Top level: quaternion in, Z-Y-X Euler angles out, fully pipelined.
// Registered stages in order: A, B, C, D, the square root chain, P, the CORDIC chains, output.
// Throughput is one item per cycle; every stage advances together whenever the
// output register is empty or its item is being taken, so a stall freezes the pipe.
// Reset (aresetn low, synchronous) clears all valid bits; data registers keep values.
module quaternion_to_euler_zyx_top import qte_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // quat_w, quat_x, quat_y, quat_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // yaw_angle, pitch_angle, roll_angle, zero pad
    output logic [0:0]  m_tuser    // pitch_clamped
);

    // The whole pipe moves as one: it advances unless the result is held.
    logic ce;
    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    // Stage A: the nine component products.
    logic signed [15:0] qw, qx, qy, qz;
    assign qw = s_tdata[15:0];
    assign qx = s_tdata[31:16];
    assign qy = s_tdata[47:32];
    assign qz = s_tdata[63:48];

    logic               va_reg;
    logic signed [31:0] wx_reg, yz_reg, xx_reg, yy_reg, wy_reg, zx_reg, wz_reg, xy_reg, zz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (ce) begin
            va_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            wx_reg <= qw * qx;
            yz_reg <= qy * qz;
            xx_reg <= qx * qx;
            yy_reg <= qy * qy;
            wy_reg <= qw * qy;
            zx_reg <= qz * qx;
            wz_reg <= qw * qz;
            xy_reg <= qx * qy;
            zz_reg <= qz * qz;
        end
    end

    // Stage B: sine and cosine arguments in Q.28, plus the pitch clamp test.
    logic signed [SW-1:0] sr_next, cr_next, sp_next, sy_next, cy_next;
    logic                 clamp_next;
    logic [27:0]          spabs_next;

    always_comb begin
        sr_next    = (SW'(wx_reg) + SW'(yz_reg)) <<< 1;
        cr_next    = ONE_Q28 - ((SW'(xx_reg) + SW'(yy_reg)) <<< 1);
        sp_next    = (SW'(wy_reg) - SW'(zx_reg)) <<< 1;
        sy_next    = (SW'(wz_reg) + SW'(xy_reg)) <<< 1;
        cy_next    = ONE_Q28 - ((SW'(yy_reg) + SW'(zz_reg)) <<< 1);
        clamp_next = (sp_next >= ONE_Q28) || (sp_next <= -ONE_Q28);
        spabs_next = sp_next[SW-1] ? 28'(-sp_next) : 28'(sp_next);
    end

    logic                 vb_reg;
    logic signed [SW-1:0] sr_b_reg, cr_b_reg, sp_b_reg, sy_b_reg, cy_b_reg;
    logic                 clamp_b_reg;
    logic [27:0]          spabs_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
        end else if (ce) begin
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            sr_b_reg    <= sr_next;
            cr_b_reg    <= cr_next;
            sp_b_reg    <= sp_next;
            sy_b_reg    <= sy_next;
            cy_b_reg    <= cy_next;
            clamp_b_reg <= clamp_next;
            spabs_b_reg <= spabs_next;
        end
    end

    // Stage C: square of the pitch sine term (only meaningful when not clamped).
    logic                 vc_reg;
    logic signed [SW-1:0] sr_c_reg, cr_c_reg, sp_c_reg, sy_c_reg, cy_c_reg;
    logic                 clamp_c_reg;
    logic [55:0]          sq_c_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg <= 1'b0;
        end else if (ce) begin
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            sr_c_reg    <= sr_b_reg;
            cr_c_reg    <= cr_b_reg;
            sp_c_reg    <= sp_b_reg;
            sy_c_reg    <= sy_b_reg;
            cy_c_reg    <= cy_b_reg;
            clamp_c_reg <= clamp_b_reg;
            sq_c_reg    <= spabs_b_reg * spabs_b_reg;
        end
    end

    // Stage D and the square root chain: cos = floor(sqrt(2^56 - sin^2)).
    logic                 vq_reg     [0:SQ_STEPS];
    logic signed [SW-1:0] sr_q_reg   [0:SQ_STEPS];
    logic signed [SW-1:0] cr_q_reg   [0:SQ_STEPS];
    logic signed [SW-1:0] sp_q_reg   [0:SQ_STEPS];
    logic signed [SW-1:0] sy_q_reg   [0:SQ_STEPS];
    logic signed [SW-1:0] cy_q_reg   [0:SQ_STEPS];
    logic                 clamp_q_reg[0:SQ_STEPS];
    sqst_t                sq_st      [0:SQ_STEPS];
    sqst_t                sq0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vq_reg[0] <= 1'b0;
        end else if (ce) begin
            vq_reg[0] <= vc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            sr_q_reg[0]    <= sr_c_reg;
            cr_q_reg[0]    <= cr_c_reg;
            sp_q_reg[0]    <= sp_c_reg;
            sy_q_reg[0]    <= sy_c_reg;
            cy_q_reg[0]    <= cy_c_reg;
            clamp_q_reg[0] <= clamp_c_reg;
            sq0_reg.rem    <= (SQW'(1) << SQ_TOP) - SQW'(sq_c_reg);
            sq0_reg.res    <= '0;
        end
    end

    assign sq_st[0] = sq0_reg;

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        qte_isqrt_step u_step (
            .aclk   (aclk),
            .ce     (ce),
            .step   (5'(k)),
            .st_in  (sq_st[k]),
            .st_out (sq_st[k+1])
        );

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vq_reg[k+1] <= 1'b0;
            end else if (ce) begin
                vq_reg[k+1] <= vq_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                sr_q_reg[k+1]    <= sr_q_reg[k];
                cr_q_reg[k+1]    <= cr_q_reg[k];
                sp_q_reg[k+1]    <= sp_q_reg[k];
                sy_q_reg[k+1]    <= sy_q_reg[k];
                cy_q_reg[k+1]    <= cy_q_reg[k];
                clamp_q_reg[k+1] <= clamp_q_reg[k];
            end
        end
    end

    // Stage P: quadrant pre-rotation of the three vectors, then the CORDIC chains.
    // Lane 0 is roll, lane 1 is yaw, lane 2 is pitch.
    logic  vp_reg    [0:CORDIC_STEPS];
    logic  zero_r_reg[0:CORDIC_STEPS];
    logic  zero_y_reg[0:CORDIC_STEPS];
    logic  clamp_p_reg[0:CORDIC_STEPS];
    logic  neg_p_reg [0:CORDIC_STEPS];
    cvec_t roll_v [0:CORDIC_STEPS];
    cvec_t yaw_v  [0:CORDIC_STEPS];
    cvec_t pit_v  [0:CORDIC_STEPS];
    cvec_t roll0_reg, yaw0_reg, pit0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vp_reg[0] <= 1'b0;
        end else if (ce) begin
            vp_reg[0] <= vq_reg[SQ_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            roll0_reg <= pre_rotate(CW'(sr_q_reg[SQ_STEPS]), CW'(cr_q_reg[SQ_STEPS]));
            yaw0_reg  <= pre_rotate(CW'(sy_q_reg[SQ_STEPS]), CW'(cy_q_reg[SQ_STEPS]));
            pit0_reg  <= pre_rotate(CW'(sp_q_reg[SQ_STEPS]),
                                    CW'(sq_st[SQ_STEPS].res));
            zero_r_reg[0]  <= (sr_q_reg[SQ_STEPS] == '0) && (cr_q_reg[SQ_STEPS] == '0);
            zero_y_reg[0]  <= (sy_q_reg[SQ_STEPS] == '0) && (cy_q_reg[SQ_STEPS] == '0);
            clamp_p_reg[0] <= clamp_q_reg[SQ_STEPS];
            neg_p_reg[0]   <= sp_q_reg[SQ_STEPS][SW-1];
        end
    end

    assign roll_v[0] = roll0_reg;
    assign yaw_v[0]  = yaw0_reg;
    assign pit_v[0]  = pit0_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        qte_cordic_step u_roll (
            .aclk  (aclk),
            .ce    (ce),
            .step  (5'(i)),
            .v_in  (roll_v[i]),
            .v_out (roll_v[i+1])
        );
        qte_cordic_step u_yaw (
            .aclk  (aclk),
            .ce    (ce),
            .step  (5'(i)),
            .v_in  (yaw_v[i]),
            .v_out (yaw_v[i+1])
        );
        qte_cordic_step u_pitch (
            .aclk  (aclk),
            .ce    (ce),
            .step  (5'(i)),
            .v_in  (pit_v[i]),
            .v_out (pit_v[i+1])
        );

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vp_reg[i+1] <= 1'b0;
            end else if (ce) begin
                vp_reg[i+1] <= vp_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                zero_r_reg[i+1]  <= zero_r_reg[i];
                zero_y_reg[i+1]  <= zero_y_reg[i];
                clamp_p_reg[i+1] <= clamp_p_reg[i];
                neg_p_reg[i+1]   <= neg_p_reg[i];
            end
        end
    end

    // Output stage: round Q.24 to Q.13 and saturate, then pick the clamp value.
    logic signed [ZW-1:0] rr, ry, rp;
    logic signed [ZW-1:0] roll_next, yaw_next, pitch_next;

    assign rr = (roll_v[CORDIC_STEPS].z + ROUND_Q11) >>> 11;
    assign ry = (yaw_v[CORDIC_STEPS].z + ROUND_Q11) >>> 11;
    assign rp = (pit_v[CORDIC_STEPS].z + ROUND_Q11) >>> 11;

    always_comb begin
        if (zero_r_reg[CORDIC_STEPS]) begin
            roll_next = '0;
        end else if (rr > PI_Q13) begin
            roll_next = PI_Q13;
        end else if (rr < -PI_Q13) begin
            roll_next = -PI_Q13;
        end else begin
            roll_next = rr;
        end

        if (zero_y_reg[CORDIC_STEPS]) begin
            yaw_next = '0;
        end else if (ry > PI_Q13) begin
            yaw_next = PI_Q13;
        end else if (ry < -PI_Q13) begin
            yaw_next = -PI_Q13;
        end else begin
            yaw_next = ry;
        end

        // A non-clamped pitch vector always has a positive cosine, never zero.
        if (clamp_p_reg[CORDIC_STEPS]) begin
            pitch_next = neg_p_reg[CORDIC_STEPS] ? -HALF_PI_Q13 : HALF_PI_Q13;
        end else if (rp > HALF_PI_Q13) begin
            pitch_next = HALF_PI_Q13;
        end else if (rp < -HALF_PI_Q13) begin
            pitch_next = -HALF_PI_Q13;
        end else begin
            pitch_next = rp;
        end
    end

    logic               vo_reg;
    logic signed [15:0] yaw_reg;
    logic signed [14:0] pitch_reg;
    logic signed [15:0] roll_reg;
    logic               clamp_o_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vo_reg <= 1'b0;
        end else if (ce) begin
            vo_reg <= vp_reg[CORDIC_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            yaw_reg     <= 16'(yaw_next);
            pitch_reg   <= 15'(pitch_next);
            roll_reg    <= 16'(roll_next);
            clamp_o_reg <= clamp_p_reg[CORDIC_STEPS];
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = {1'b0, roll_reg, pitch_reg, yaw_reg};
    assign m_tuser  = clamp_o_reg;

    // A clamped pitch is always exactly plus or minus pi/2.
    a_clamp_pitch: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && clamp_o_reg) |-> (pitch_reg == 15'sd12868 || pitch_reg == -15'sd12868))
        else $error("clamped pitch is not pi/2");

    // A sine term that passed the clamp test fits the 28-bit square path.
    a_sine_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (vb_reg && !clamp_b_reg) |-> (sp_b_reg < ONE_Q28 && sp_b_reg > -ONE_Q28))
        else $error("unclamped sine term out of range");

    // Yaw and roll never leave the range of plus or minus pi.
    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (yaw_reg <= 16'sd25736 && yaw_reg >= -16'sd25736 &&
                      roll_reg <= 16'sd25736 && roll_reg >= -16'sd25736))
        else $error("yaw or roll out of range");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule
